[sv/emst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emst_pkg
// Shared types and constants of the euclidean spanning tree length core.
// ----------------------------------------------------------------------------
package emst_pkg;

  // default sizing
  localparam int DefMaxPoints = 128;
  localparam int DefCoordBits = 24;

  // fixed result field widths
  localparam int TotalBits = 32;
  localparam int CountBits = 8;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_RDU,
    ST_LDU,
    ST_NEXT,
    ST_DIFF,
    ST_MUL,
    ST_SUM,
    ST_SQRT,
    ST_UPD,
    ST_RND,
    ST_FIN
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic store;
    logic start;
    logic rd_u;
    logic ld_u;
    logic skip;
    logic rd_j;
    logic diff;
    logic mul;
    logic sum;
    logic sqrt_step;
    logic upd;
    logic round_end;
    logic out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic single;
    logic j_done;
    logic j_in_tree;
    logic sqrt_last;
    logic last_round;
    logic out_busy;
  } sts_t;

endpackage

[sv/emst_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emst_in_if
// Point input channel: valid/ready handshake with coordinates and last mark.
// ----------------------------------------------------------------------------
interface emst_in_if #(
  parameter int CoordBits = emst_pkg::DefCoordBits
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] x_coord;
  logic signed [CoordBits-1:0] y_coord;
  logic                        last_point;

  modport source (output valid, x_coord, y_coord, last_point, input ready);
  modport sink (input valid, x_coord, y_coord, last_point, output ready);
endinterface

[sv/emst_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emst_out_if
// Result channel: valid/ready handshake with tree length, count and overflow.
// ----------------------------------------------------------------------------
interface emst_out_if;
  logic                           valid;
  logic                           ready;
  logic [emst_pkg::TotalBits-1:0] total_length;
  logic [emst_pkg::CountBits-1:0] point_count;
  logic                           overflow;

  modport source (output valid, total_length, point_count, overflow, input ready);
  modport sink (input valid, total_length, point_count, overflow, output ready);
endinterface

[sv/euclidean_mst_length_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclidean_mst_length_core
// Spanning tree length of a set of 2-D fixed point points.
// ----------------------------------------------------------------------------
// Usage:
//  - in_i carries one point per transaction (x_coord, y_coord, last_point).
//    Points load at one per cycle until MaxPoints are held; further points
//    are dropped and flagged in the result.
//  - A transaction with last_point set closes the set and starts the tree
//    build; in_i ready stays low until the result is handed to the output
//    register.
//  - The tree is grown one point per round, n-1 rounds for n points. Each
//    round walks every point: a point already in the tree is skipped,
//    any other goes through the weight steps (read, difference, square,
//    bit-serial square root of CoordBits + 2 steps, update); each round also
//    reads its new tree point first and closes with a round end step.
//  - out_o carries one result per set: total_length (saturating, fraction
//    bits as the inputs), point_count and overflow.
//  - The result waits in an output register while out_o is stalled; new
//    points are accepted meanwhile, and the next result waits for it.
//  - Reset empties the point set and drops any pending result.
// ----------------------------------------------------------------------------
module euclidean_mst_length_core #(
  parameter int MaxPoints = emst_pkg::DefMaxPoints,
  parameter int CoordBits = emst_pkg::DefCoordBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  emst_in_if.sink     in_i,
  emst_out_if.source  out_o
);

  emst_pkg::cmd_t cmd;
  emst_pkg::sts_t sts;

  // sequencer
  emst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_point),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage and arithmetic
  emst_dp #(
    .MaxPoints (MaxPoints),
    .CoordBits (CoordBits)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .x_coord_i      (in_i.x_coord),
    .y_coord_i      (in_i.y_coord),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .total_length_o (out_o.total_length),
    .point_count_o  (out_o.point_count),
    .overflow_o     (out_o.overflow)
  );

endmodule

[sv/emst_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emst_ctrl
// Sequencer: point loading, prim rounds, per-candidate weight steps, result.
// ----------------------------------------------------------------------------
module emst_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  input  emst_pkg::sts_t sts_i,
  output emst_pkg::cmd_t cmd_o
);

  emst_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= emst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      emst_pkg::ST_IDLE: begin
        if (in_valid_i && in_last_i) state_d = emst_pkg::ST_START;
      end
      emst_pkg::ST_START: begin
        state_d = sts_i.single ? emst_pkg::ST_FIN : emst_pkg::ST_RDU;
      end
      emst_pkg::ST_RDU:  state_d = emst_pkg::ST_LDU;
      emst_pkg::ST_LDU:  state_d = emst_pkg::ST_NEXT;
      emst_pkg::ST_NEXT: begin
        if (sts_i.j_done) state_d = emst_pkg::ST_RND;
        else if (!sts_i.j_in_tree) state_d = emst_pkg::ST_DIFF;
      end
      emst_pkg::ST_DIFF: state_d = emst_pkg::ST_MUL;
      emst_pkg::ST_MUL:  state_d = emst_pkg::ST_SUM;
      emst_pkg::ST_SUM:  state_d = emst_pkg::ST_SQRT;
      emst_pkg::ST_SQRT: begin
        if (sts_i.sqrt_last) state_d = emst_pkg::ST_UPD;
      end
      emst_pkg::ST_UPD:  state_d = emst_pkg::ST_NEXT;
      emst_pkg::ST_RND: begin
        state_d = sts_i.last_round ? emst_pkg::ST_FIN : emst_pkg::ST_RDU;
      end
      emst_pkg::ST_FIN: begin
        if (!sts_i.out_busy) state_d = emst_pkg::ST_IDLE;
      end
      default: state_d = emst_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      emst_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.store = in_valid_i;
      end
      emst_pkg::ST_START: cmd_o.start = 1'b1;
      emst_pkg::ST_RDU:   cmd_o.rd_u  = 1'b1;
      emst_pkg::ST_LDU:   cmd_o.ld_u  = 1'b1;
      emst_pkg::ST_NEXT: begin
        if (!sts_i.j_done) begin
          cmd_o.skip = sts_i.j_in_tree;
          cmd_o.rd_j = !sts_i.j_in_tree;
        end
      end
      emst_pkg::ST_DIFF:  cmd_o.diff      = 1'b1;
      emst_pkg::ST_MUL:   cmd_o.mul       = 1'b1;
      emst_pkg::ST_SUM:   cmd_o.sum       = 1'b1;
      emst_pkg::ST_SQRT:  cmd_o.sqrt_step = 1'b1;
      emst_pkg::ST_UPD:   cmd_o.upd       = 1'b1;
      emst_pkg::ST_RND:   cmd_o.round_end = 1'b1;
      emst_pkg::ST_FIN:   cmd_o.out_load  = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

[sv/emst_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emst_dp
// Datapath: point memories, distance memory, tree membership bits, weight
// unit (abs difference, squares, bit-serial square root) and accumulator.
// ----------------------------------------------------------------------------
module emst_dp #(
  parameter int MaxPoints = emst_pkg::DefMaxPoints,
  parameter int CoordBits = emst_pkg::DefCoordBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  emst_pkg::cmd_t                 cmd_i,
  output emst_pkg::sts_t                 sts_o,
  input  logic [CoordBits-1:0]           x_coord_i,
  input  logic [CoordBits-1:0]           y_coord_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [emst_pkg::TotalBits-1:0] total_length_o,
  output logic [emst_pkg::CountBits-1:0] point_count_o,
  output logic                           overflow_o
);

  localparam int IW = $clog2(MaxPoints);
  localparam int CW = $clog2(MaxPoints + 1);
  localparam int DW = CoordBits + 1;      // abs difference
  localparam int PW = 2 * DW;             // square
  localparam int RW = CoordBits + 2;      // root
  localparam int SW = 2 * RW;             // radicand
  localparam int QW = $clog2(RW);         // root step counter
  localparam int AW = ((RW > emst_pkg::TotalBits) ? RW : emst_pkg::TotalBits) + 1;
  localparam logic [emst_pkg::TotalBits-1:0] TotMax = '1;

  // memories
  logic [CoordBits-1:0] x_mem [MaxPoints];
  logic [CoordBits-1:0] y_mem [MaxPoints];
  logic [RW-1:0]        dist_mem [MaxPoints];
  logic [CoordBits-1:0] x_rd_q, y_rd_q;
  logic [RW-1:0]        dist_rd_q;

  // control registers
  logic [CW-1:0]        count_q, n_q, j_q, rounds_q;
  logic                 dropped_q, first_q, best_valid_q, sat_q, out_valid_q;
  logic [MaxPoints-1:0] in_tree_q;
  logic [QW-1:0]        sq_cnt_q;

  // payload registers
  logic [IW-1:0]                u_q, bu_q;
  logic [CoordBits-1:0]         ux_q, uy_q;
  logic [DW-1:0]                dx_q, dy_q;
  logic [PW-1:0]                sqx_q, sqy_q;
  logic [SW-1:0]                op_q, res_q, one_q;
  logic [RW-1:0]                best_q;
  logic [emst_pkg::TotalBits-1:0] total_q, res_total_q;
  logic [emst_pkg::CountBits-1:0] res_count_q;
  logic                         res_ovf_q;

  logic          can_store;
  logic [IW-1:0] rd_addr;
  logic signed [DW-1:0] ddx, ddy;
  logic [SW-1:0] trial;
  logic [RW-1:0] w_cur, d_new;
  logic [AW-1:0] acc_sum;

  assign can_store = (count_q < CW'(MaxPoints));
  assign rd_addr   = cmd_i.rd_u ? u_q : j_q[IW-1:0];

  // point memories: write on load, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && can_store) begin
      x_mem[count_q[IW-1:0]] <= x_coord_i;
      y_mem[count_q[IW-1:0]] <= y_coord_i;
    end
    if (cmd_i.rd_u || cmd_i.rd_j) begin
      x_rd_q <= x_mem[rd_addr];
      y_rd_q <= y_mem[rd_addr];
    end
  end

  // distance memory: best known link of each point to the tree
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) dist_mem[j_q[IW-1:0]] <= d_new;
    if (cmd_i.rd_j) dist_rd_q <= dist_mem[j_q[IW-1:0]];
  end

  // set bookkeeping and tree membership
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      dropped_q    <= 1'b0;
      n_q          <= '0;
      j_q          <= '0;
      rounds_q     <= '0;
      first_q      <= 1'b0;
      best_valid_q <= 1'b0;
      sat_q        <= 1'b0;
      in_tree_q    <= '0;
      sq_cnt_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.store) begin
        if (can_store) count_q <= count_q + 1'b1;
        else dropped_q <= 1'b1;
      end
      if (cmd_i.start) begin
        n_q          <= count_q;
        rounds_q     <= count_q - 1'b1;
        first_q      <= 1'b1;
        sat_q        <= 1'b0;
        in_tree_q    <= MaxPoints'(1);
      end
      if (cmd_i.ld_u) begin
        j_q          <= '0;
        best_valid_q <= 1'b0;
      end
      if (cmd_i.skip || cmd_i.upd) j_q <= j_q + 1'b1;
      if (cmd_i.sum) sq_cnt_q <= '0;
      if (cmd_i.sqrt_step) sq_cnt_q <= sq_cnt_q + 1'b1;
      if (cmd_i.upd) best_valid_q <= 1'b1;
      if (cmd_i.round_end) begin
        in_tree_q[bu_q] <= 1'b1;
        rounds_q        <= rounds_q - 1'b1;
        first_q         <= 1'b0;
        if (!sat_q && (acc_sum > AW'(TotMax))) sat_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        count_q     <= '0;
        dropped_q   <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // weight unit arithmetic
  assign ddx   = $signed({x_rd_q[CoordBits-1], x_rd_q}) - $signed({ux_q[CoordBits-1], ux_q});
  assign ddy   = $signed({y_rd_q[CoordBits-1], y_rd_q}) - $signed({uy_q[CoordBits-1], uy_q});
  assign trial = res_q + one_q;
  assign w_cur = res_q[RW-1:0];
  assign d_new = (first_q || (w_cur < dist_rd_q)) ? w_cur : dist_rd_q;
  assign acc_sum = AW'(total_q) + AW'(best_q);

  // weight pipeline, selection and accumulation
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      u_q     <= '0;
      total_q <= '0;
    end
    if (cmd_i.ld_u) begin
      ux_q <= x_rd_q;
      uy_q <= y_rd_q;
    end
    if (cmd_i.diff) begin
      dx_q <= ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
      dy_q <= ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
    end
    if (cmd_i.mul) begin
      sqx_q <= dx_q * dx_q;
      sqy_q <= dy_q * dy_q;
    end
    // square root, one result bit per step
    if (cmd_i.sum) begin
      op_q  <= SW'(sqx_q) + SW'(sqy_q);
      res_q <= '0;
      one_q <= SW'(1) << (SW - 2);
    end
    if (cmd_i.sqrt_step) begin
      if (op_q >= trial) begin
        op_q  <= op_q - trial;
        res_q <= (res_q >> 1) + one_q;
      end else begin
        res_q <= res_q >> 1;
      end
      one_q <= one_q >> 2;
    end
    if (cmd_i.upd && (!best_valid_q || (d_new < best_q))) begin
      best_q <= d_new;
      bu_q   <= j_q[IW-1:0];
    end
    if (cmd_i.round_end) begin
      u_q <= bu_q;
      if (!sat_q) begin
        total_q <= (acc_sum > AW'(TotMax)) ? TotMax : acc_sum[emst_pkg::TotalBits-1:0];
      end
    end
    if (cmd_i.out_load) begin
      res_total_q <= total_q;
      res_count_q <= emst_pkg::CountBits'(n_q);
      res_ovf_q   <= dropped_q || sat_q;
    end
  end

  // status, single point taken from the live count while starting
  assign sts_o.single     = (count_q == CW'(1));
  assign sts_o.j_done     = (j_q == n_q);
  assign sts_o.j_in_tree  = in_tree_q[j_q[IW-1:0]];
  assign sts_o.sqrt_last  = (sq_cnt_q == QW'(RW - 1));
  assign sts_o.last_round = (rounds_q == CW'(1));
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign total_length_o = res_total_q;
  assign point_count_o  = res_count_q;
  assign overflow_o     = res_ovf_q;

  // checks
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxPoints)) else $error("point count above capacity");
  a_start_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> n_q != '0) else $error("computation started on empty set");
  a_upd_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd |=> best_valid_q) else $error("candidate update left no best edge");
  a_round_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.round_end |-> best_valid_q) else $error("round closed without a candidate");

endmodule
